@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the heater controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ihc_pkg.sv @@
`timescale 1ns / 1ps

package ihc_pkg;

   // Field widths.
   localparam int RAW_W     = 10;
   localparam int ADC_BITS  = 10;
   localparam int TARGET_W  = 9;
   localparam int MEAS_W    = 10;
   localparam int DELAY_W   = 14;
   localparam int STEP_W    = 10;
   localparam int BYTE_W    = 8;

   localparam logic [TARGET_W-1:0] TARGET_MAX = {TARGET_W{1'b1}};
   localparam logic [DELAY_W-1:0]  TICK_MAX   = {DELAY_W{1'b1}};

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_LIMIT      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_STEP      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_LIMIT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SP_THRESHOLD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_HEAT_MRG  = 3'd5;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_FALL   = 2'd1,
      OP_RISE   = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   // One classified item waiting for the back end.
   typedef struct packed {
      op_type              op;
      logic [TARGET_W-1:0] sp_iron;
      logic [TARGET_W-1:0] sp_air;
      logic [MEAS_W-1:0]   thermo_iron;
      logic [MEAS_W-1:0]   thermo_air;
   } entry_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  slew_limit;
      logic [BYTE_W-1:0]  deadband_offset;
      logic [STEP_W-1:0]  delay_step;
      logic [DELAY_W-1:0] delay_limit;
      logic [BYTE_W-1:0]  setpoint_threshold;
      logic [BYTE_W-1:0]  first_heat_margin;
   } cfg_type;

   // Queue status seen by the front and back.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

@@ rtl/iron_and_air_heater_controller.sv @@
`timescale 1ns / 1ps

// Channel   | Handshake                  | Payload
// ----------+----------------------------+---------------------------------------------
// req_      | req_valid / req_stall      | operation, four 10-bit ADC readings
// rsp_      | rsp_valid / rsp_stall      | heater, triac, targets, measured, delay
// csr_      | csr_psel / csr_penable     | six control registers, 32-bit data
//
// An accepted item is held in the front queue, then in the state/result register,
// before it leaves as a result; a stalled result side keeps it in the queue.
// One item per cycle is sustained while the result side does not stall, as the back end updates all state at once.
// Reset is synchronous and active high; it empties the queue, clears all state
// and loads the register defaults, with no clearing pass afterwards.
// A stalled result holds the back end; the two-entry queue then fills and stalls requests.

module iron_and_air_heater_controller (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_operation,
   input  logic [ihc_pkg::RAW_W-1:0]             req_setpoint_iron_raw,
   input  logic [ihc_pkg::RAW_W-1:0]             req_setpoint_air_raw,
   input  logic [ihc_pkg::RAW_W-1:0]             req_thermo_iron_raw,
   input  logic [ihc_pkg::RAW_W-1:0]             req_thermo_air_raw,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_heater_on,
   output logic                                  rsp_triac_on,
   output logic [ihc_pkg::TARGET_W-1:0]          rsp_target_iron,
   output logic [ihc_pkg::TARGET_W-1:0]          rsp_target_air,
   output logic [ihc_pkg::MEAS_W-1:0]            rsp_measured_iron,
   output logic [ihc_pkg::MEAS_W-1:0]            rsp_measured_air,
   output logic [ihc_pkg::DELAY_W-1:0]           rsp_firing_delay,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ihc_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [ihc_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [ihc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   ihc_pkg::cfg_type    cfg_ff, cfg_in;
   ihc_pkg::entry_type  push_entry;
   ihc_pkg::entry_type  head_entry;
   ihc_pkg::qstat_type  qstat;
   logic                push;
   logic                pop;
   logic                csr_write;
   logic [ihc_pkg::CSR_IDX_W-1:0] csr_idx;

   // Registers sit on word addresses; the low two address bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[ihc_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_idx)
            ihc_pkg::CSR_SLEW_LIMIT:
               cfg_in.slew_limit = csr_pwdata[ihc_pkg::BYTE_W-1:0];
            ihc_pkg::CSR_DEADBAND_OFFSET:
               cfg_in.deadband_offset = csr_pwdata[ihc_pkg::BYTE_W-1:0];
            ihc_pkg::CSR_DELAY_STEP:
               cfg_in.delay_step = csr_pwdata[ihc_pkg::STEP_W-1:0];
            ihc_pkg::CSR_DELAY_LIMIT:
               cfg_in.delay_limit = csr_pwdata[ihc_pkg::DELAY_W-1:0];
            ihc_pkg::CSR_SP_THRESHOLD:
               cfg_in.setpoint_threshold = csr_pwdata[ihc_pkg::BYTE_W-1:0];
            ihc_pkg::CSR_FIRST_HEAT_MRG:
               cfg_in.first_heat_margin = csr_pwdata[ihc_pkg::BYTE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         ihc_pkg::CSR_SLEW_LIMIT:
            csr_prdata = ihc_pkg::CSR_DATA_W'(cfg_ff.slew_limit);
         ihc_pkg::CSR_DEADBAND_OFFSET:
            csr_prdata = ihc_pkg::CSR_DATA_W'(cfg_ff.deadband_offset);
         ihc_pkg::CSR_DELAY_STEP:
            csr_prdata = ihc_pkg::CSR_DATA_W'(cfg_ff.delay_step);
         ihc_pkg::CSR_DELAY_LIMIT:
            csr_prdata = ihc_pkg::CSR_DATA_W'(cfg_ff.delay_limit);
         ihc_pkg::CSR_SP_THRESHOLD:
            csr_prdata = ihc_pkg::CSR_DATA_W'(cfg_ff.setpoint_threshold);
         ihc_pkg::CSR_FIRST_HEAT_MRG:
            csr_prdata = ihc_pkg::CSR_DATA_W'(cfg_ff.first_heat_margin);
         default:
            csr_prdata = '0;
      endcase
   end

   // Register defaults match the controller's power-on tuning.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slew_limit         <= 8'd15;
         cfg_ff.deadband_offset    <= 8'd5;
         cfg_ff.delay_step         <= 10'd10;
         cfg_ff.delay_limit        <= 14'd10000;
         cfg_ff.setpoint_threshold <= 8'd4;
         cfg_ff.first_heat_margin  <= 8'd15;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front decodes and scales each item and drops it in the queue.
   ihc_front u_front (
      .req_valid             (req_valid),
      .req_operation         (req_operation),
      .req_setpoint_iron_raw (req_setpoint_iron_raw),
      .req_setpoint_air_raw  (req_setpoint_air_raw),
      .req_thermo_iron_raw   (req_thermo_iron_raw),
      .req_thermo_air_raw    (req_thermo_air_raw),
      .qstat                 (qstat),
      .req_stall             (req_stall),
      .push                  (push),
      .push_entry            (push_entry)
   );

   // The queue lets the request side keep going while a result waits.
   ihc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .qstat      (qstat)
   );

   // The back end runs the control laws and timer and presents the state.
   ihc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .head_entry        (head_entry),
      .qstat             (qstat),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_heater_on     (rsp_heater_on),
      .rsp_triac_on      (rsp_triac_on),
      .rsp_target_iron   (rsp_target_iron),
      .rsp_target_air    (rsp_target_air),
      .rsp_measured_iron (rsp_measured_iron),
      .rsp_measured_air  (rsp_measured_air),
      .rsp_firing_delay  (rsp_firing_delay)
   );

endmodule

@@ rtl/ihc_front.sv @@
`timescale 1ns / 1ps

// Accepts items, decodes the operation and scales both setpoint readings.
module ihc_front (
   input  logic                            req_valid,
   input  logic [1:0]                      req_operation,
   input  logic [ihc_pkg::RAW_W-1:0]       req_setpoint_iron_raw,
   input  logic [ihc_pkg::RAW_W-1:0]       req_setpoint_air_raw,
   input  logic [ihc_pkg::RAW_W-1:0]       req_thermo_iron_raw,
   input  logic [ihc_pkg::RAW_W-1:0]       req_thermo_air_raw,
   input  ihc_pkg::qstat_type              qstat,
   output logic                            req_stall,
   output logic                            push,
   output ihc_pkg::entry_type              push_entry
);

   localparam int WIDE_W = ihc_pkg::RAW_W + ihc_pkg::TARGET_W;

   function automatic logic [ihc_pkg::TARGET_W-1:0] scale_sp(
      input logic [ihc_pkg::RAW_W-1:0] raw
   );
      logic [WIDE_W-1:0] wide;
      wide = {raw, {ihc_pkg::TARGET_W{1'b0}}} >> ihc_pkg::ADC_BITS;
      if (wide > WIDE_W'(ihc_pkg::TARGET_MAX)) begin
         scale_sp = ihc_pkg::TARGET_MAX;
      end else begin
         scale_sp = wide[ihc_pkg::TARGET_W-1:0];
      end
   endfunction

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   always_comb begin
      push_entry.op          = ihc_pkg::op_type'(req_operation);
      push_entry.sp_iron     = scale_sp(req_setpoint_iron_raw);
      push_entry.sp_air      = scale_sp(req_setpoint_air_raw);
      push_entry.thermo_iron = req_thermo_iron_raw;
      push_entry.thermo_air  = req_thermo_air_raw;
   end

endmodule

@@ rtl/ihc_queue.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Small first-in first-out queue of classified items.
module ihc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ihc_pkg::entry_type   push_entry,
   input  logic                 pop,
   output ihc_pkg::entry_type   head_entry,
   output ihc_pkg::qstat_type   qstat
);

   ihc_pkg::entry_type               ent_ff [ihc_pkg::QUEUE_DEPTH];
   logic [ihc_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ihc_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ihc_pkg::QCNT_W-1:0]       count_ff, count_in;

   function automatic logic [ihc_pkg::QPTR_W-1:0] next_ptr(
      input logic [ihc_pkg::QPTR_W-1:0] ptr
   );
      if (ptr == ihc_pkg::QPTR_W'(ihc_pkg::QUEUE_DEPTH - 1)) begin
         next_ptr = '0;
      end else begin
         next_ptr = ptr + 1'b1;
      end
   endfunction

   assign qstat.full  = (count_ff == ihc_pkg::QCNT_W'(ihc_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_entry  = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `IHC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= ihc_pkg::QCNT_W'(ihc_pkg::QUEUE_DEPTH), "queue count above depth")
   `IHC_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !qstat.empty, "pop from empty queue")
   `IHC_ASSERT_NOW(a_no_push_full, clock, reset, push, !qstat.full, "push into full queue")

endmodule

@@ rtl/ihc_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Carries out one queued item per cycle while the result side does not stall, and holds the
// controller state, which doubles as the result register.
module ihc_back (
   input  logic                            clock,
   input  logic                            reset,
   input  ihc_pkg::cfg_type                cfg,
   input  ihc_pkg::entry_type              head_entry,
   input  ihc_pkg::qstat_type              qstat,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_heater_on,
   output logic                            rsp_triac_on,
   output logic [ihc_pkg::TARGET_W-1:0]    rsp_target_iron,
   output logic [ihc_pkg::TARGET_W-1:0]    rsp_target_air,
   output logic [ihc_pkg::MEAS_W-1:0]      rsp_measured_iron,
   output logic [ihc_pkg::MEAS_W-1:0]      rsp_measured_air,
   output logic [ihc_pkg::DELAY_W-1:0]     rsp_firing_delay
);

   localparam int TW = ihc_pkg::TARGET_W;
   localparam int MW = ihc_pkg::MEAS_W;
   localparam int DW = ihc_pkg::DELAY_W;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]   tgt_iron_ff, tgt_iron_in;
   logic [TW-1:0]   tgt_air_ff, tgt_air_in;
   logic [MW-1:0]   meas_iron_ff, meas_iron_in;
   logic [MW-1:0]   meas_air_ff, meas_air_in;
   logic [DW-1:0]   delay_ff, delay_in;
   logic [DW-1:0]   tick_ff, tick_in;
   logic            running_ff, running_in;
   logic            heater_ff, heater_in;
   logic            triac_ff, triac_in;
   logic            first_done_ff, first_done_in;

   logic [MW:0]     air_ref;
   logic [MW:0]     iron_ref;
   logic [MW:0]     iron_first;
   logic [DW:0]     delay_up;
   logic [DW-1:0]   tick_next;

   // The setpoint is taken over only when it moves by more than the threshold.
   function automatic logic [TW-1:0] take_sp(
      input logic [TW-1:0]                  held,
      input logic [TW-1:0]                  x,
      input logic [ihc_pkg::BYTE_W-1:0]     thr
   );
      logic [TW-1:0] diff;
      diff = (x > held) ? (x - held) : (held - x);
      take_sp = (diff > TW'(thr)) ? x : held;
   endfunction

   // Moves the held temperature toward the reading by at most the slew limit.
   function automatic logic [MW-1:0] slew(
      input logic [MW-1:0]                  m,
      input logic [MW-1:0]                  x,
      input logic [ihc_pkg::BYTE_W-1:0]     lim
   );
      logic [MW:0] up;
      up = {1'b0, m} + (MW+1)'(lim);
      if (x > m && (x - m) > MW'(lim)) begin
         slew = up[MW-1:0];
      end else if (m > x && (m - x) > MW'(lim)) begin
         slew = m - MW'(lim);
      end else begin
         slew = x;
      end
   endfunction

   assign pop          = !qstat.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

   always_comb begin
      tgt_iron_in   = tgt_iron_ff;
      tgt_air_in    = tgt_air_ff;
      meas_iron_in  = meas_iron_ff;
      meas_air_in   = meas_air_ff;
      delay_in      = delay_ff;
      tick_in       = tick_ff;
      running_in    = running_ff;
      heater_in     = heater_ff;
      triac_in      = triac_ff;
      first_done_in = first_done_ff;

      tick_next  = (tick_ff != ihc_pkg::TICK_MAX) ? tick_ff + 1'b1 : tick_ff;
      air_ref    = '0;
      iron_ref   = '0;
      iron_first = '0;
      delay_up   = '0;

      if (pop) begin
         case (head_entry.op)
            ihc_pkg::OP_SAMPLE: begin
               tgt_iron_in  = take_sp(tgt_iron_ff, head_entry.sp_iron,
                                      cfg.setpoint_threshold);
               tgt_air_in   = take_sp(tgt_air_ff, head_entry.sp_air,
                                      cfg.setpoint_threshold);
               meas_iron_in = slew(meas_iron_ff, head_entry.thermo_iron, cfg.slew_limit);
               meas_air_in  = slew(meas_air_ff, head_entry.thermo_air, cfg.slew_limit);

               // Hot air: nudge the firing delay against the deadband reference.
               air_ref  = {1'b0, meas_air_in} + (MW+1)'(cfg.deadband_offset);
               delay_up = {1'b0, delay_ff} + (DW+1)'(cfg.delay_step);
               if ((MW+1)'(tgt_air_in) > air_ref) begin
                  if (DW'(cfg.delay_step) > delay_ff) begin
                     delay_in = '0;
                  end else begin
                     delay_in = delay_ff - DW'(cfg.delay_step);
                  end
               end else if ((MW+1)'(tgt_air_in) < air_ref) begin
                  if (delay_up > (DW+1)'(cfg.delay_limit)) begin
                     delay_in = cfg.delay_limit;
                  end else begin
                     delay_in = delay_up[DW-1:0];
                  end
               end

               // Iron: the first-heat check compares target plus margin with
               // the measured value, so no negative numbers arise.
               iron_first = (MW+1)'(tgt_iron_in) + (MW+1)'(cfg.first_heat_margin);
               if (!first_done_ff) begin
                  if (iron_first < {1'b0, meas_iron_in}) begin
                     heater_in = 1'b1;
                  end else if (iron_first > {1'b0, meas_iron_in}) begin
                     heater_in     = 1'b0;
                     first_done_in = 1'b1;
                  end
               end
               iron_ref = {1'b0, meas_iron_in} + (MW+1)'(cfg.deadband_offset);
               if ((MW+1)'(tgt_iron_in) > iron_ref) begin
                  heater_in = 1'b1;
               end else if ((MW+1)'(tgt_iron_in) < iron_ref) begin
                  heater_in = 1'b0;
               end
            end
            ihc_pkg::OP_FALL: begin
               tick_in    = '0;
               running_in = 1'b1;
            end
            ihc_pkg::OP_RISE: begin
               tick_in    = '0;
               running_in = 1'b0;
               triac_in   = 1'b0;
            end
            ihc_pkg::OP_TICK: begin
               if (running_ff) begin
                  tick_in = tick_next;
                  if (tick_next > delay_ff) begin
                     triac_in = 1'b1;
                  end
               end
            end
            default: begin
               tick_in = tick_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         tgt_iron_ff   <= '0;
         tgt_air_ff    <= '0;
         meas_iron_ff  <= '0;
         meas_air_ff   <= '0;
         delay_ff      <= '0;
         tick_ff       <= '0;
         running_ff    <= 1'b0;
         heater_ff     <= 1'b0;
         triac_ff      <= 1'b0;
         first_done_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         tgt_iron_ff   <= tgt_iron_in;
         tgt_air_ff    <= tgt_air_in;
         meas_iron_ff  <= meas_iron_in;
         meas_air_ff   <= meas_air_in;
         delay_ff      <= delay_in;
         tick_ff       <= tick_in;
         running_ff    <= running_in;
         heater_ff     <= heater_in;
         triac_ff      <= triac_in;
         first_done_ff <= first_done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heater_on     = heater_ff;
   assign rsp_triac_on      = triac_ff;
   assign rsp_target_iron   = tgt_iron_ff;
   assign rsp_target_air    = tgt_air_ff;
   assign rsp_measured_iron = meas_iron_ff;
   assign rsp_measured_air  = meas_air_ff;
   assign rsp_firing_delay  = delay_ff;

   `IHC_ASSERT_NEXT(a_rise_stops, clock, reset, pop && head_entry.op == ihc_pkg::OP_RISE, !triac_ff && !running_ff && tick_ff == '0, "rising zero cross left timer or triac active")
   `IHC_ASSERT_NEXT(a_idle_tick, clock, reset, pop && head_entry.op == ihc_pkg::OP_TICK && !running_ff, $stable(tick_ff) && $stable(triac_ff), "tick changed a stopped timer")
   `IHC_ASSERT_NEXT(a_state_hold, clock, reset, !pop, $stable(delay_ff) && $stable(heater_ff) && $stable(tgt_iron_ff), "state changed without an item")

endmodule
